/* sv/rrse_pkg.sv */
// Shared types, format helpers and estimate tables for the reciprocal estimate unit.
`timescale 1ns / 1ps
package rrse_pkg;

  typedef enum logic [2:0] {
    OP_RECIP  = 3'd0,
    OP_RSQRT  = 3'd1,
    OP_RECPX  = 3'd2,
    OP_URECIP = 3'd3,
    OP_URSQRT = 3'd4
  } op_t;

  localparam logic [1:0] PREC_HALF   = 2'd0;
  localparam logic [1:0] PREC_SINGLE = 2'd1;
  localparam logic [1:0] PREC_DOUBLE = 2'd2;
  localparam logic [1:0] PREC_RSVD   = 2'd3;

  localparam logic [1:0] RM_NEAREST = 2'd0;
  localparam logic [1:0] RM_PLUS    = 2'd1;
  localparam logic [1:0] RM_MINUS   = 2'd2;

  localparam logic [7:0] REG_ROUNDING = 8'd0;
  localparam logic [7:0] REG_FTZ      = 8'd1;
  localparam logic [7:0] REG_FTZ_HALF = 8'd2;
  localparam logic [7:0] REG_DN       = 8'd3;

  // Exponent adjustment applied to a reciprocal result.
  localparam logic [1:0] FIX_NONE = 2'd0;
  localparam logic [1:0] FIX_ZERO = 2'd1;
  localparam logic [1:0] FIX_NEG  = 2'd2;

  typedef struct packed {
    logic id;
    logic ix;
    logic uf;
    logic of;
    logic dz;
    logic inv;
  } flags_t;

  typedef struct packed {
    logic [1:0] rounding_mode;
    logic       flush_to_zero;
    logic       flush_to_zero_half;
    logic       default_nan_mode;
  } cfg_t;

  // Unpacked and classified operand.
  typedef struct packed {
    logic        special;
    logic [63:0] spec_res;
    flags_t      flags;
    logic        is_rsqrt;
    logic        is_uint;
    logic [1:0]  prec;
    logic        sign;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [8:0]  uidx;
  } s1_t;

  // Normalized operand, ready for the table lookup.
  typedef struct packed {
    logic        special;
    logic [63:0] spec_res;
    flags_t      flags;
    logic        is_rsqrt;
    logic        is_uint;
    logic [1:0]  prec;
    logic        sign;
    logic [10:0] re;
    logic [1:0]  fix;
    logic [8:0]  idx;
  } s3_t;

  typedef logic [8:0] rtab_t [256];
  typedef logic [8:0] stab_t [384];

  function automatic logic [10:0] emax_of(input logic [1:0] prec);
    case (prec)
      PREC_HALF:   emax_of = 11'h01F;
      PREC_SINGLE: emax_of = 11'h0FF;
      default:     emax_of = 11'h7FF;
    endcase
  endfunction

  function automatic logic [11:0] bias_of(input logic [1:0] prec);
    case (prec)
      PREC_HALF:   bias_of = 12'd15;
      PREC_SINGLE: bias_of = 12'd127;
      default:     bias_of = 12'd1023;
    endcase
  endfunction

  // Packs sign, biased exponent and a left-justified 52-bit fraction.
  function automatic logic [63:0] pack_fp(input logic [1:0] prec, input logic sign,
                                          input logic [10:0] e, input logic [51:0] f);
    case (prec)
      PREC_HALF:   pack_fp = {48'd0, sign, e[4:0], f[51:42]};
      PREC_SINGLE: pack_fp = {32'd0, sign, e[7:0], f[51:29]};
      default:     pack_fp = {sign, e, f};
    endcase
  endfunction

  // Reciprocal entry: (floor(2^19 / (2a+1)) + 1) / 2, by restoring division.
  function automatic logic [8:0] recip_entry(input int a);
    int d;
    int rem;
    int q;
    d = a * 2 + 1;
    rem = 0;
    q = 0;
    for (int i = 19; i >= 0; i--) begin
      rem = rem * 2 + ((i == 19) ? 1 : 0);
      q = q * 2;
      if (rem >= d) begin
        rem = rem - d;
        q = q + 1;
      end
    end
    recip_entry = 9'((q + 1) >> 1);
  endfunction

  function automatic logic [8:0] rsqrt_entry(input int a);
    longint d;
    longint b;
    d = (a < 256) ? longint'(a * 2 + 1) : longint'((((a >> 1) << 1) + 1) * 2);
    b = 512;
    while (d * (b + 1) * (b + 1) < (longint'(1) << 28))
      b++;
    rsqrt_entry = 9'((b + 1) >> 1);
  endfunction

  function automatic rtab_t build_recip();
    rtab_t t;
    for (int i = 0; i < 256; i++)
      t[i] = recip_entry(256 + i);
    return t;
  endfunction

  function automatic stab_t build_rsqrt();
    stab_t t;
    for (int i = 0; i < 384; i++)
      t[i] = rsqrt_entry(128 + i);
    return t;
  endfunction

  localparam rtab_t RECIP_TAB = build_recip();
  localparam stab_t RSQRT_TAB = build_rsqrt();

endpackage

/* sv/rrse_unpack.sv */
// First stage: field extraction, flushing and special-case results.
`timescale 1ns / 1ps
module rrse_unpack (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0]          opcode,
  input  logic [1:0]          precision,
  input  logic [63:0]         operand,
  input  rrse_pkg::cfg_t      cfg,
  output logic                out_valid,
  output rrse_pkg::s1_t       out
);

  rrse_pkg::s1_t s;
  logic [10:0] emax;
  logic [11:0] bias;
  logic        fz;
  logic        emax_hit;
  logic        nan;
  logic [63:0] nan_res;
  logic        nan_inv;
  logic        to_inf;
  logic [31:0] v;

  always_comb begin
    s = '0;
    v = operand[31:0];
    emax = rrse_pkg::emax_of(precision);
    bias = rrse_pkg::bias_of(precision);
    fz = (precision == rrse_pkg::PREC_HALF) ? cfg.flush_to_zero_half : cfg.flush_to_zero;
    s.prec = precision;
    case (precision)
      rrse_pkg::PREC_HALF: begin
        s.sign = operand[15];
        s.ex = {6'd0, operand[14:10]};
        s.frac = {operand[9:0], 42'd0};
      end
      rrse_pkg::PREC_SINGLE: begin
        s.sign = operand[31];
        s.ex = {3'd0, operand[30:23]};
        s.frac = {operand[22:0], 29'd0};
      end
      default: begin
        s.sign = operand[63];
        s.ex = operand[62:52];
        s.frac = operand[51:0];
      end
    endcase
    // Denormal input flushed to a signed zero; half format raises no flag.
    if (s.ex == 11'd0 && s.frac != 52'd0 && fz) begin
      s.flags.id = (precision != rrse_pkg::PREC_HALF);
      if (opcode != rrse_pkg::OP_RECPX)
        s.frac = '0;
    end
    emax_hit = (s.ex == emax);
    nan = emax_hit && s.frac != 52'd0;
    nan_inv = !s.frac[51];
    nan_res = cfg.default_nan_mode ? rrse_pkg::pack_fp(precision, 1'b0, emax, {1'b1, 51'd0})
                                   : rrse_pkg::pack_fp(precision, s.sign, s.ex,
                                                       s.frac | {1'b1, 51'd0});
    to_inf = cfg.rounding_mode == rrse_pkg::RM_NEAREST ||
             (cfg.rounding_mode == rrse_pkg::RM_PLUS && !s.sign) ||
             (cfg.rounding_mode == rrse_pkg::RM_MINUS && s.sign);
    s.uidx = v[31:23];
    s.special = 1'b1;
    case (opcode)
      rrse_pkg::OP_RECIP: begin
        if (precision == rrse_pkg::PREC_RSVD) begin
          s.flags = '0;
        end else if (nan) begin
          s.spec_res = nan_res;
          s.flags.inv = nan_inv;
        end else if (emax_hit) begin
          s.spec_res = rrse_pkg::pack_fp(precision, s.sign, 11'd0, 52'd0);
        end else if (s.ex == 11'd0 && s.frac == 52'd0) begin
          s.spec_res = rrse_pkg::pack_fp(precision, s.sign, emax, 52'd0);
          s.flags.dz = 1'b1;
        end else if (s.ex == 11'd0 && s.frac[51:50] == 2'b00) begin
          s.spec_res = to_inf ? rrse_pkg::pack_fp(precision, s.sign, emax, 52'd0)
                              : rrse_pkg::pack_fp(precision, s.sign, emax - 11'd1, '1);
          s.flags.of = 1'b1;
          s.flags.ix = 1'b1;
        end else if (fz && {1'b0, s.ex} >= (bias << 1) - 12'd1) begin
          s.spec_res = rrse_pkg::pack_fp(precision, s.sign, 11'd0, 52'd0);
          s.flags.uf = 1'b1;
        end else begin
          s.special = 1'b0;
        end
      end
      rrse_pkg::OP_RSQRT: begin
        s.is_rsqrt = 1'b1;
        if (precision == rrse_pkg::PREC_RSVD) begin
          s.flags = '0;
        end else if (nan) begin
          s.spec_res = nan_res;
          s.flags.inv = nan_inv;
        end else if (s.ex == 11'd0 && s.frac == 52'd0) begin
          s.spec_res = rrse_pkg::pack_fp(precision, s.sign, emax, 52'd0);
          s.flags.dz = 1'b1;
        end else if (s.sign) begin
          s.spec_res = rrse_pkg::pack_fp(precision, 1'b0, emax, {1'b1, 51'd0});
          s.flags.inv = 1'b1;
        end else if (emax_hit) begin
          s.spec_res = '0;
        end else begin
          s.special = 1'b0;
        end
      end
      rrse_pkg::OP_RECPX: begin
        if (precision == rrse_pkg::PREC_RSVD) begin
          s.flags = '0;
        end else if (nan) begin
          s.spec_res = nan_res;
          s.flags.inv = nan_inv;
        end else begin
          s.spec_res = rrse_pkg::pack_fp(precision, s.sign,
                                         (s.ex == 11'd0) ? emax - 11'd1 : (~s.ex & emax),
                                         52'd0);
        end
      end
      rrse_pkg::OP_URECIP, rrse_pkg::OP_URSQRT: begin
        s.flags = '0;
        s.is_uint = 1'b1;
        s.is_rsqrt = (opcode == rrse_pkg::OP_URSQRT);
        if (s.is_rsqrt ? v[31:30] == 2'b00 : !v[31])
          s.spec_res = {32'd0, 32'hFFFF_FFFF};
        else
          s.special = 1'b0;
      end
      default: begin
        s.flags = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= s;
    end
  end

endmodule

/* sv/rrse_norm.sv */
// Second and third stages: leading-zero count, normalization and result exponent.
`timescale 1ns / 1ps
module rrse_norm (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rrse_pkg::s1_t   in,
  output logic            out_valid,
  output rrse_pkg::s3_t   out
);

  rrse_pkg::s1_t s2;
  logic          v2;
  logic [5:0]    lz_c;
  logic [5:0]    lz;
  rrse_pkg::s3_t s3;
  logic [51:0]   f;
  logic signed [12:0] e;
  logic signed [12:0] re;
  logic [11:0]   bias;

  always_comb begin
    lz_c = 6'd52;
    for (int i = 0; i < 52; i++)
      if (in.frac[i])
        lz_c = 6'(51 - i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2 <= in_valid;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= in;
      lz <= lz_c;
      out <= s3;
    end
  end

  always_comb begin
    bias = rrse_pkg::bias_of(s2.prec);
    f = s2.frac;
    e = signed'({2'b00, s2.ex});
    re = '0;
    s3 = '0;
    s3.special = s2.special;
    s3.spec_res = s2.spec_res;
    s3.flags = s2.flags;
    s3.is_rsqrt = s2.is_rsqrt;
    s3.is_uint = s2.is_uint;
    s3.prec = s2.prec;
    s3.sign = s2.sign;
    s3.fix = rrse_pkg::FIX_NONE;
    if (s2.is_uint) begin
      s3.idx = s2.uidx;
    end else if (s2.is_rsqrt) begin
      if (s2.ex == 11'd0) begin
        f = s2.frac << (lz + 6'd1);
        e = -signed'({7'd0, lz});
      end
      s3.idx = e[0] ? {2'b01, f[51:45]} : {1'b1, f[51:44]};
      re = (signed'({1'b0, bias} * 13'sd3) - 13'sd1 - e) >>> 1;
      s3.re = re[10:0];
    end else begin
      if (s2.ex == 11'd0) begin
        if (!s2.frac[51]) begin
          e = -13'sd1;
          f = s2.frac << 2;
        end else begin
          f = s2.frac << 1;
        end
      end
      s3.idx = {1'b1, f[51:44]};
      re = signed'({1'b0, bias << 1}) - 13'sd1 - e;
      if (re == 13'sd0) begin
        s3.fix = rrse_pkg::FIX_ZERO;
      end else if (re == -13'sd1) begin
        s3.fix = rrse_pkg::FIX_NEG;
        re = '0;
      end
      s3.re = re[10:0];
    end
  end

endmodule

/* sv/rrse_lookup.sv */
// Fourth and fifth stages: estimate table read and result assembly.
`timescale 1ns / 1ps
module rrse_lookup (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rrse_pkg::s3_t   in,
  output logic            out_valid,
  output logic [63:0]     result,
  output rrse_pkg::flags_t flags
);

  rrse_pkg::s3_t s4;
  logic          v4;
  logic [8:0]    est;
  logic [8:0]    sidx;
  logic [63:0]   res_c;
  logic [51:0]   fr;

  assign sidx = in.idx - 9'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4 <= in;
      est <= in.is_rsqrt ? rrse_pkg::RSQRT_TAB[sidx] : rrse_pkg::RECIP_TAB[in.idx[7:0]];
      result <= res_c;
      flags <= s4.flags;
    end
  end

  always_comb begin
    case (s4.fix)
      rrse_pkg::FIX_ZERO: fr = {1'b1, est[7:0], 43'd0};
      rrse_pkg::FIX_NEG:  fr = {2'b01, est[7:0], 42'd0};
      default:            fr = {est[7:0], 44'd0};
    endcase
    if (s4.special)
      res_c = s4.spec_res;
    else if (s4.is_uint)
      res_c = {32'd0, est, 23'd0};
    else if (s4.is_rsqrt)
      res_c = rrse_pkg::pack_fp(s4.prec, 1'b0, s4.re, {est[7:0], 44'd0});
    else
      res_c = rrse_pkg::pack_fp(s4.prec, s4.sign, s4.re, fr);
  end

endmodule

/* sv/recip_rsqrt_estimate_unit.sv */
// Top level of the reciprocal and reciprocal square-root estimate unit.
//
//  channel   handshake                 payload
//  s_axis    s_tvalid / s_tready       s_tdata: opcode, precision, operand
//  m_axis    m_tvalid / m_tready       m_tdata: result, six exception flags
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Every item passes through unpack and classify, leading-zero count,
// normalization, estimate table read and result assembly into the output
// register. One item is taken every cycle when not stalled; the table ROM read
// sets the stage cut. All stages advance together whenever the output register
// is empty or read, so a stall holds every item in place and loses nothing.
// Reset is synchronous and clears the valid bits and the configuration registers.
// The configuration port always accepts a write.
`timescale 1ns / 1ps
module recip_rsqrt_estimate_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] opcode, [4:3] precision, [68:5] operand, [71:69] zero
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [63:0] result, [64] invalid, [65] div_by_zero, [66] overflow,
  // [67] underflow, [68] inexact, [69] input_denormal, [71:70] zero
  output logic [71:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  rrse_pkg::cfg_t   cfg;
  logic             en;
  logic             v1;
  logic             v3;
  rrse_pkg::s1_t    s1;
  rrse_pkg::s3_t    s3;
  logic [63:0]      result;
  rrse_pkg::flags_t flags;

  // The whole pipeline moves when the output register can take a new item.
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rrse_pkg::REG_ROUNDING: cfg.rounding_mode <= cfg_data[1:0];
        rrse_pkg::REG_FTZ:      cfg.flush_to_zero <= cfg_data[0];
        rrse_pkg::REG_FTZ_HALF: cfg.flush_to_zero_half <= cfg_data[0];
        rrse_pkg::REG_DN:       cfg.default_nan_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rrse_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .opcode    (s_tdata[2:0]),
    .precision (s_tdata[4:3]),
    .operand   (s_tdata[68:5]),
    .cfg       (cfg),
    .out_valid (v1),
    .out       (s1)
  );

  rrse_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in        (s1),
    .out_valid (v3),
    .out       (s3)
  );

  rrse_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in        (s3),
    .out_valid (m_tvalid),
    .result    (result),
    .flags     (flags)
  );

  assign m_tdata = {2'b00, flags.id, flags.ix, flags.uf, flags.of, flags.dz, flags.inv, result};

endmodule

/* sv/rrse_checker.sv */
// Port-level checks for the estimate unit and their binding to the top level.
`timescale 1ns / 1ps
module rrse_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // A result that is not taken stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  // Overflow always comes with inexact.
  a_of_ix: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[66] |-> m_tdata[68])
    else $error("overflow without inexact");

  // Divide by zero excludes invalid, overflow and underflow.
  a_dz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[65] |-> !m_tdata[64] && !m_tdata[66] && !m_tdata[67])
    else $error("divide by zero with a conflicting flag");

  // Right after reset no item is presented.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  // The input side is ready whenever the output register is free.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind recip_rsqrt_estimate_unit rrse_checker u_rrse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/tb.sv */
// Self-checking testbench for the reciprocal and reciprocal square-root estimate unit.
`timescale 1ns / 1ps
module tb;

  // Flag positions within m_tdata[69:64], lowest bit first.
  localparam int FLAG_INV = 0;
  localparam int FLAG_DZ  = 1;
  localparam int FLAG_OF  = 2;
  localparam int FLAG_UF  = 3;
  localparam int FLAG_IX  = 4;
  localparam int FLAG_ID  = 5;
  localparam logic [1:0] RM_ZERO   = 2'd3;
  localparam logic [1:0] PREC_BAD  = 2'd3;
  localparam logic [2:0] OP_TOP    = 3'h7;
  localparam logic [63:0] FRAC52_MASK = (64'd1 << 52) - 64'd1;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [63:0] res;
    logic [5:0]  fl;
  } estimate_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;

  // Shadow copy of the configuration registers.
  logic [1:0] round_mode;
  logic       ftz_wide;
  logic       ftz_half;
  logic       dnan_mode;

  estimate_t pending_estimates[$];
  int        error_count;
  int        rx_mode;
  int        hold_requests;
  int        hold_served;
  int        hold_left;
  int        stall_phase;
  int        burst_left;

  recip_rsqrt_estimate_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Reciprocal table rule: half of (2^19 / (2a+1)) rounded up.
  function automatic int unsigned recip_lookup(int unsigned a);
    int unsigned q;
    q = (32'd1 << 19) / (a * 2 + 1);
    return (q + 1) / 2;
  endfunction

  // Square-root table rule: (b+1)/2 for the least b >= 512 with d*(b+1)^2 >= 2^28.
  function automatic int unsigned rsqrt_lookup(int unsigned a);
    longint unsigned d;
    longint unsigned b;
    d = (a < 256) ? a * 2 + 1 : (((a >> 1) << 1) + 1) * 2;
    b = 512;
    while (d * (b + 1) * (b + 1) < (64'd1 << 28))
      b++;
    return int'((b + 1) / 2);
  endfunction

  // Computes the result and flags that the unit should give for one item,
  // using the shadow configuration.
  function automatic estimate_t compute_estimate(logic [2:0] op, logic [1:0] prec,
                                                 logic [63:0] a);
    estimate_t   r;
    int          mant;
    int          bias;
    int          spos;
    int          e;
    int          re;
    int unsigned est;
    int unsigned sc;
    logic [63:0] emax;
    logic [63:0] mmask;
    logic [63:0] wmask;
    logic [63:0] qbit;
    logic [63:0] sgn;
    logic [63:0] frac;
    logic [63:0] ex;
    logic [63:0] fr;
    logic [31:0] v;
    bit          fz;
    bit          to_inf;
    r.res = '0;
    r.fl  = '0;
    if (op == rrse_pkg::OP_URECIP || op == rrse_pkg::OP_URSQRT) begin
      v = a[31:0];
      if (op == rrse_pkg::OP_URSQRT ? v[31:30] == 2'b00 : v[31] == 1'b0) begin
        r.res = 64'hFFFF_FFFF;
      end else begin
        est = (op == rrse_pkg::OP_URSQRT) ? rsqrt_lookup(v >> 23) : recip_lookup(v >> 23);
        r.res = (64'(est) << 23) & 64'hFFFF_FFFF;
      end
      return r;
    end
    if (op > rrse_pkg::OP_RECPX || prec > rrse_pkg::PREC_DOUBLE)
      return r;
    case (prec)
      rrse_pkg::PREC_HALF: begin
        mant = 10; emax = 64'h1F; bias = 15; spos = 15; fz = ftz_half;
      end
      rrse_pkg::PREC_SINGLE: begin
        mant = 23; emax = 64'hFF; bias = 127; spos = 31; fz = ftz_wide;
      end
      default: begin
        mant = 52; emax = 64'h7FF; bias = 1023; spos = 63; fz = ftz_wide;
      end
    endcase
    wmask = (spos == 63) ? '1 : (64'd1 << (spos + 1)) - 64'd1;
    mmask = (64'd1 << mant) - 64'd1;
    qbit  = 64'd1 << (mant - 1);
    a = a & wmask;
    // Denormal inputs are flushed to a signed zero; the half format raises no
    // input-denormal flag for it. A NaN is never a denormal, so the order of
    // this step and the NaN test does not matter for any operation.
    if (((a >> mant) & emax) == 0 && (a & mmask) != 0 && fz) begin
      if (prec != rrse_pkg::PREC_HALF)
        r.fl[FLAG_ID] = 1'b1;
      a = a & (64'd1 << spos);
    end
    sgn  = a & (64'd1 << spos);
    frac = a & mmask;
    ex   = (a >> mant) & emax;
    if (ex == emax && frac != 0) begin
      if ((a & qbit) == 0)
        r.fl[FLAG_INV] = 1'b1;
      r.res = dnan_mode ? ((emax << mant) | qbit) : (a | qbit);
      return r;
    end
    case (op)
      rrse_pkg::OP_RECIP: begin
        if (ex == emax) begin
          r.res = sgn;
        end else if (ex == 0 && frac == 0) begin
          r.fl[FLAG_DZ] = 1'b1;
          r.res = sgn | (emax << mant);
        end else if (ex == 0 && (frac >> (mant - 2)) == 0) begin
          // A tiny denormal overflows; the rounding mode picks infinity or max.
          to_inf = round_mode == rrse_pkg::RM_NEAREST ||
                   (round_mode == rrse_pkg::RM_PLUS && sgn == 0) ||
                   (round_mode == rrse_pkg::RM_MINUS && sgn != 0);
          r.fl[FLAG_OF] = 1'b1;
          r.fl[FLAG_IX] = 1'b1;
          r.res = sgn | (to_inf ? (emax << mant) : (((emax - 1) << mant) | mmask));
        end else if (fz && ex >= 64'(2 * bias - 1)) begin
          r.fl[FLAG_UF] = 1'b1;
          r.res = sgn;
        end else begin
          fr = frac << (52 - mant);
          e = int'(ex);
          if (e == 0) begin
            if (fr[51] == 1'b0) begin
              e = -1;
              fr = (fr << 2) & FRAC52_MASK;
            end else begin
              fr = (fr << 1) & FRAC52_MASK;
            end
          end
          est = recip_lookup(256 + fr[51:44]);
          re = 2 * bias - 1 - e;
          fr = 64'(est & 32'hFF) << 44;
          if (re == 0) begin
            fr = (64'd1 << 51) | (fr >> 1);
          end else if (re == -1) begin
            fr = (64'd1 << 50) | (fr >> 2);
            re = 0;
          end
          r.res = sgn | (64'(re) << mant) | (fr >> (52 - mant));
        end
      end
      rrse_pkg::OP_RSQRT: begin
        if (ex == 0 && frac == 0) begin
          r.fl[FLAG_DZ] = 1'b1;
          r.res = sgn | (emax << mant);
        end else if (sgn != 0) begin
          r.fl[FLAG_INV] = 1'b1;
          r.res = (emax << mant) | qbit;
        end else if (ex == emax) begin
          r.res = '0;
        end else begin
          fr = frac << (52 - mant);
          e = int'(ex);
          if (e == 0) begin
            while (fr[51] == 1'b0) begin
              fr = (fr << 1) & FRAC52_MASK;
              e--;
            end
            fr = (fr << 1) & FRAC52_MASK;
          end
          sc = (e & 1) ? 128 + fr[51:45] : 256 + fr[51:44];
          re = (3 * bias - 1 - e) / 2;
          est = rsqrt_lookup(sc);
          r.res = (64'(re) << mant) | (64'(est & 32'hFF) << (mant - 8));
        end
      end
      default: begin
        r.res = sgn | (((ex == 0) ? emax - 1 : (~ex & emax)) << mant);
      end
    endcase
    r.res = r.res & wmask;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("error at %0t: %s expected %h, got %h", $realtime, field, want, got);
    error_count++;
  endtask

  // Every accepted input item gets its expected result queued.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      pending_estimates.push_back(compute_estimate(s_tdata[2:0], s_tdata[4:3],
                                                   s_tdata[68:5]));
  end

  // Every accepted result item is checked against the oldest expectation.
  always @(posedge clk) begin
    estimate_t want;
    string names[6];
    names = '{"invalid", "div_by_zero", "overflow", "underflow", "inexact",
              "input_denormal"};
    if (!rst && m_tvalid && m_tready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("unexpected result", '0, m_tdata[63:0]);
      end else begin
        want = pending_estimates.pop_front();
        if (m_tdata[63:0] !== want.res)
          report_mismatch("result", want.res, m_tdata[63:0]);
        for (int i = 0; i < 6; i++)
          if (m_tdata[64 + i] !== want.fl[i])
            report_mismatch(names[i], want.fl[i], m_tdata[64 + i]);
      end
    end
  end

  // Receiver: stalls per rx_mode, and serves long hold requests by counting
  // the hold down here, cycle by cycle.
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 7;
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= (stall_phase >= 3);
      endcase
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high so a following item can go out back to back.
  task automatic send_item(logic [2:0] op, logic [1:0] prec, logic [63:0] operand);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, operand, prec, op};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_estimates.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= {$urandom, $urandom} & ~64'h3 | 64'(val);
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  // Writes all four registers; only called while the unit is idle.
  task automatic set_config(logic [1:0] rm, logic fzw, logic fzh, logic dn);
    drain();
    write_reg(rrse_pkg::REG_ROUNDING, rm);
    write_reg(rrse_pkg::REG_FTZ, {1'b0, fzw});
    write_reg(rrse_pkg::REG_FTZ_HALF, {1'b0, fzh});
    write_reg(rrse_pkg::REG_DN, {1'b0, dn});
    cfg_valid <= 1'b0;
    round_mode = rm;
    ftz_wide   = fzw;
    ftz_half   = fzh;
    dnan_mode  = dn;
  endtask

  // Builds an operand around the interesting exponents and fractions of a
  // format, with junk in the bits above the format width.
  function automatic logic [63:0] pick_operand(logic [1:0] prec);
    int          mant;
    int          bias;
    int          spos;
    logic [63:0] emax;
    logic [63:0] mmask;
    logic [63:0] wmask;
    logic [63:0] ex;
    logic [63:0] frac;
    logic [63:0] a;
    a = {$urandom, $urandom};
    if (prec > rrse_pkg::PREC_DOUBLE || $urandom_range(0, 15) == 0)
      return a;
    case (prec)
      rrse_pkg::PREC_HALF: begin
        mant = 10; emax = 64'h1F; bias = 15; spos = 15;
      end
      rrse_pkg::PREC_SINGLE: begin
        mant = 23; emax = 64'hFF; bias = 127; spos = 31;
      end
      default: begin
        mant = 52; emax = 64'h7FF; bias = 1023; spos = 63;
      end
    endcase
    wmask = (spos == 63) ? '1 : (64'd1 << (spos + 1)) - 64'd1;
    mmask = (64'd1 << mant) - 64'd1;
    case ($urandom_range(0, 7))
      0: ex = 0;
      1: ex = emax;
      2: ex = emax - 1;
      3: ex = 64'(2 * bias - 2 + $urandom_range(0, 2));
      4: ex = 1;
      default: ex = {$urandom, $urandom} & emax;
    endcase
    case ($urandom_range(0, 5))
      0: frac = 0;
      1: frac = 64'($urandom_range(1, 3));
      2: frac = (64'd1 << (mant - 1)) | 64'($urandom_range(0, 1));
      3: frac = 64'($urandom_range(1, 7)) << (mant - 3);
      default: frac = {$urandom, $urandom} & mmask;
    endcase
    return (a & ~wmask) | (64'($urandom_range(0, 1)) << spos) | (ex << mant) | frac;
  endfunction

  task automatic send_random_item();
    logic [2:0] op;
    logic [1:0] prec;
    op = (($urandom_range(0, 19) == 0)
          ? 3'($urandom_range(rrse_pkg::OP_URSQRT + 1, OP_TOP))
          : 3'($urandom_range(rrse_pkg::OP_RECIP, rrse_pkg::OP_URSQRT)));
    prec = ($urandom_range(0, 19) == 0)
           ? PREC_BAD
           : 2'($urandom_range(rrse_pkg::PREC_HALF, rrse_pkg::PREC_DOUBLE));
    if (op == rrse_pkg::OP_URECIP || op == rrse_pkg::OP_URSQRT)
      send_item(op, 2'($urandom), {$urandom, $urandom_range(0, 1) ? $urandom
                                   : ($urandom | 32'h8000_0000)});
    else
      send_item(op, prec, pick_operand(prec));
  endtask

  // Sender in bursts of random length with random gaps between them.
  task automatic send_burst_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0)
          idle_cycles($urandom_range(1, 9));
      end
      burst_left--;
      send_random_item();
    end
  endtask

  // Extremes and special cases under the reset configuration.
  task automatic test_directed();
    rx_mode = 0;
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_SINGLE, 64'h3F80_0000);
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_SINGLE, 64'hFFFF_FFFF_0000_0000);
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_DOUBLE, 64'h8000_0000_0000_0000);
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_SINGLE, 64'h7F80_0000);
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_SINGLE, 64'h7F80_0001);
    send_item(rrse_pkg::OP_RSQRT, rrse_pkg::PREC_SINGLE, 64'h7FC0_0000);
    send_item(rrse_pkg::OP_RSQRT, rrse_pkg::PREC_SINGLE, 64'hBF80_0000);
    send_item(rrse_pkg::OP_RSQRT, rrse_pkg::PREC_DOUBLE, 64'h7FF0_0000_0000_0000);
    send_item(rrse_pkg::OP_RSQRT, rrse_pkg::PREC_HALF, 64'h0001);
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_HALF, 64'h8001);
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_SINGLE, 64'h0040_0000);
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_SINGLE, 64'h7E80_0000);
    send_item(rrse_pkg::OP_RECPX, rrse_pkg::PREC_DOUBLE, 64'h7FF0_0000_0000_0001);
    send_item(rrse_pkg::OP_RECPX, rrse_pkg::PREC_HALF, 64'hFFFF_FFFF_FFFF_0000);
    send_item(rrse_pkg::OP_RECPX, rrse_pkg::PREC_SINGLE, 64'h8080_0000);
    send_item(rrse_pkg::OP_URECIP, rrse_pkg::PREC_HALF, 64'h7FFF_FFFF);
    send_item(rrse_pkg::OP_URECIP, PREC_BAD, 64'hFFFF_FFFF_8000_0000);
    send_item(rrse_pkg::OP_URSQRT, rrse_pkg::PREC_SINGLE, 64'h3FFF_FFFF);
    send_item(rrse_pkg::OP_URSQRT, rrse_pkg::PREC_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(rrse_pkg::OP_URSQRT + 3'd1, rrse_pkg::PREC_SINGLE, 64'h3F80_0000);
    send_item(OP_TOP, rrse_pkg::PREC_DOUBLE, '1);
    send_item(rrse_pkg::OP_RECIP, PREC_BAD, 64'h3F80_0000);
    send_item(rrse_pkg::OP_RECIP, rrse_pkg::PREC_DOUBLE, 64'h7FEF_FFFF_FFFF_FFFF);
    send_item(rrse_pkg::OP_RSQRT, rrse_pkg::PREC_DOUBLE, 64'h0000_0000_0000_0001);
    drain();
  endtask

  // Flush, rounding and default-NaN settings, the extremes among them.
  task automatic test_config_sweep();
    for (int rm = rrse_pkg::RM_NEAREST; rm <= RM_ZERO; rm++) begin
      for (int k = 0; k < 2; k++) begin
        set_config(2'(rm), k[0], ~k[0], k[0] ^ rm[0]);
        rx_mode = (rm + k) % 3;
        send_burst_traffic(50);
      end
    end
    set_config(RM_ZERO, 1'b1, 1'b1, 1'b1);
    send_burst_traffic(50);
  endtask

  // Long receiver hold while the sender keeps offering, so the unit backs up.
  task automatic test_backpressure();
    set_config(rrse_pkg::RM_MINUS, 1'b1, 1'b0, 1'b0);
    rx_mode = 0;
    hold_requests++;
    for (int i = 0; i < 80; i++)
      send_random_item();
    drain();
  endtask

  // Bulk random traffic with configuration changes between phases, and
  // sender pauses until everything has drained.
  task automatic test_random();
    for (int phase = 0; phase < 12; phase++) begin
      set_config(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      rx_mode = $urandom_range(0, 2);
      send_burst_traffic(75);
      drain();
      send_burst_traffic(30);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    round_mode = rrse_pkg::RM_NEAREST;
    ftz_wide = 1'b0;
    ftz_half = 1'b0;
    dnan_mode = 1'b0;
    error_count = 0;
    rx_mode = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    stall_phase = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("recip_rsqrt_estimate_unit: match");
    end else begin
      $display("recip_rsqrt_estimate_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("recip_rsqrt_estimate_unit: mismatch");
    $finish;
  end

endmodule

/* files.f */
sv/rrse_pkg.sv
sv/rrse_unpack.sv
sv/rrse_norm.sv
sv/rrse_lookup.sv
sv/recip_rsqrt_estimate_unit.sv
sv/rrse_checker.sv
verif/tb.sv
